### hw/rtl/stb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the software timer bank: command codes,
// stream field widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package stb_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int IDX_IN_W   = 3;
    localparam int DATA_W     = 32;

    // Stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = CMD_W + IDX_IN_W + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + DATA_W + DATA_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Command codes
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_TICK  = 2'd0;
    localparam cmd_t CMD_SET   = 2'd1;
    localparam cmd_t CMD_CHECK = 2'd2;
    localparam cmd_t CMD_FORCE = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch request, start table read
        logic commit;   // update state, load result register
    } stb_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // result register can take a new result
    } stb_stat_t;

endpackage

### hw/rtl/stb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_ctrl
// Two-state sequencer: takes a request, then commits it once the result
// register is free.
// ----------------------------------------------------------------------------
module stb_ctrl
    import stb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  stb_stat_t stat,
    output stb_ctrl_t ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        ctrl.accept = 1'b0;
        ctrl.commit = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.accept = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    ctrl.commit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/stb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_datapath
// Tick and seconds counters, timer start/duration memories, expired flags
// and the result register.
// ----------------------------------------------------------------------------
module stb_datapath
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS       = 8,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  stb_ctrl_t            ctrl,
    output stb_stat_t            stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int RES_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    // Residue of 0xFFFFFFFF, the counter value after wrapping from zero
    localparam logic [63:0] WRAP_RES64 = 64'hFFFF_FFFF % 64'(TICKS_PER_SECOND);
    localparam logic [RES_W-1:0] WRAP_RES = RES_W'(WRAP_RES64);
    localparam logic [RES_W-1:0] TPS_M1   = RES_W'(TICKS_PER_SECOND - 1);

    // Input fields
    cmd_t                in_cmd;
    logic [IDX_IN_W-1:0] in_idx;
    logic [DATA_W-1:0]   in_dur;
    logic [IDX_W-1:0]    in_addr;

    assign in_cmd  = s_tdata[CMD_W-1:0];
    assign in_idx  = s_tdata[CMD_W +: IDX_IN_W];
    assign in_dur  = s_tdata[CMD_W+IDX_IN_W +: DATA_W];
    assign in_addr = IDX_W'(32'(in_idx));

    // Latched request
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic              valid_reg;
    logic [DATA_W-1:0] dur_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            cmd_reg   <= in_cmd;
            addr_reg  <= in_addr;
            valid_reg <= (32'(in_idx) < 32'(NUM_TIMERS));
            dur_reg   <= in_dur;
        end
    end

    // Counters and flags
    logic [DATA_W-1:0]     tick_cnt_reg;
    logic [DATA_W-1:0]     tick_cnt_next;
    logic [RES_W-1:0]      res_reg;
    logic [RES_W-1:0]      res_next;
    logic [DATA_W-1:0]     sec_cnt_reg;
    logic [DATA_W-1:0]     sec_cnt_next;
    logic [NUM_TIMERS-1:0] expired_reg;

    // Timer memories
    logic [DATA_W-1:0] start_mem [NUM_TIMERS];
    logic [DATA_W-1:0] dur_mem   [NUM_TIMERS];
    logic [DATA_W-1:0] start_rd_reg;
    logic [DATA_W-1:0] dur_rd_reg;

    logic [DATA_W-1:0] elapsed;
    logic              fire;
    logic              do_set;
    logic              do_force;

    // Memory write on commit of set, registered read on accept
    always_ff @(posedge aclk) begin
        if (do_set) begin
            start_mem[addr_reg] <= tick_cnt_reg;
            dur_mem[addr_reg]   <= dur_reg;
        end
        if (ctrl.accept) begin
            start_rd_reg <= start_mem[in_addr];
            dur_rd_reg   <= dur_mem[in_addr];
        end
    end

    // Command decode
    assign do_set   = ctrl.commit && (cmd_reg == CMD_SET) && valid_reg;
    assign do_force = ctrl.commit && (cmd_reg == CMD_FORCE) && valid_reg;
    assign elapsed  = start_rd_reg - tick_cnt_reg;
    assign fire     = (cmd_reg == CMD_CHECK) && valid_reg && !expired_reg[addr_reg]
                      && (elapsed > dur_rd_reg);

    // Tick: residue tracks counter modulo ticks per second
    always_comb begin
        tick_cnt_next = tick_cnt_reg;
        res_next      = res_reg;
        sec_cnt_next  = sec_cnt_reg;
        if (cmd_reg == CMD_TICK) begin
            tick_cnt_next = tick_cnt_reg - 32'd1;
            if (tick_cnt_reg == '0) begin
                res_next = WRAP_RES;
            end else if (res_reg == '0) begin
                res_next = TPS_M1;
            end else begin
                res_next = res_reg - RES_W'(1);
            end
            if (res_next == '0) begin
                sec_cnt_next = sec_cnt_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_cnt_reg <= '0;
            res_reg      <= '0;
            sec_cnt_reg  <= '0;
            expired_reg  <= '1;
        end else if (ctrl.commit) begin
            tick_cnt_reg <= tick_cnt_next;
            res_reg      <= res_next;
            sec_cnt_reg  <= sec_cnt_next;
            if (do_set) begin
                expired_reg[addr_reg] <= 1'b0;
            end
            if (do_force || fire) begin
                expired_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign stat.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            m_tdata_reg <= M_TDATA_W'({sec_cnt_next, tick_cnt_next, fire});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> (!m_tvalid_reg || m_tready))
        else $error("commit while result register is occupied");

    a_res_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(res_reg) < 32'(TICKS_PER_SECOND))
        else $error("tick residue out of range");

    a_fire_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.commit && fire) |=> expired_reg[$past(addr_reg)])
        else $error("fired timer not marked expired");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.accept |=> !ctrl.accept)
        else $error("request accepted while one is in progress");
`endif

endmodule

### hw/rtl/software_timer_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of one-shot timers on a down-counting tick counter that steps once per tick request.
//
// Input stream s_*: one request per transfer (tick, set, check, force).
// Output stream m_*: exactly one result per request, in request order,
// carrying the expiry flag, the tick counter and uptime seconds.
// A request is taken with a registered timer-table read, then committed
// once the result register is free, which loads its result. The next
// request is taken only after the previous one has been committed.
// A new request is taken while the previous result still waits on m_*.
// If the receiver stalls, the result is held and the block stops after
// one more request until the result register frees up.
// Reset (aresetn low, synchronous) clears the tick counter and seconds,
// marks every timer expired and drops m_tvalid; table contents are
// undefined until a set writes them.
// ----------------------------------------------------------------------------
module software_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS       = 8,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] command, [4:2] timer_index, [36:5] duration_ms, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] expired_now, [32:1] tick_count, [64:33] uptime_seconds, rest zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    stb_ctrl_t ctrl;
    stb_stat_t stat;

    // Sequencer
    stb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // Counters, tables and result register
    stb_datapath #(
        .NUM_TIMERS       (NUM_TIMERS),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .ctrl     (ctrl),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
